@@ rtl/masu_pkg.sv @@
package masu_pkg;

   localparam int IDX_W   = 10;
   localparam int VAL_W   = 32;
   localparam int WIDTH_W = 31;
   localparam int CFG_W   = 24;

   // Q8.16 unity, used when the width is kept as is
   localparam logic [CFG_W-1:0] Q_ONE = 24'd65536;

   localparam logic [CFG_W-1:0] EXPANSION_RESET   = 24'd78643;
   localparam logic [CFG_W-1:0] CONTRACTION_RESET = 24'd26214;
   localparam logic [CFG_W-1:0] MIN_SCALE_RESET   = 24'd655;
   localparam logic [CFG_W-1:0] MAX_SCALE_RESET   = 24'd655360;

   typedef enum logic [1:0] {
      CSR_EXPANSION   = 2'd0,
      CSR_CONTRACTION = 2'd1,
      CSR_MIN_SCALE   = 2'd2,
      CSR_MAX_SCALE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] expansion_factor;
      logic [CFG_W-1:0] contraction_factor;
      logic [CFG_W-1:0] min_width_scale;
      logic [CFG_W-1:0] max_width_scale;
   } cfg_type;

   // one history slot
   typedef struct packed {
      logic signed [VAL_W-1:0] prev_value;
      logic signed [VAL_W-1:0] older_value;
      logic [WIDTH_W-1:0]      width;
   } hist_entry_type;

   // request as it enters the update pipeline
   typedef struct packed {
      logic                    valid;
      logic [IDX_W-1:0]        var_index;
      logic signed [VAL_W-1:0] current_value;
      logic signed [VAL_W-1:0] upper_bound;
      logic signed [VAL_W-1:0] lower_bound;
      logic                    pass_end;
      logic                    warm;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0]   out_index;
      logic [WIDTH_W-1:0] new_width;
      logic               out_last;
   } result_type;

endpackage

@@ rtl/masu_if.sv @@
interface masu_req_if;
   import masu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        var_index;
   logic signed [VAL_W-1:0] current_value;
   logic signed [VAL_W-1:0] upper_bound;
   logic signed [VAL_W-1:0] lower_bound;
   logic                    pass_end;

   modport source (
      output valid, var_index, current_value, upper_bound, lower_bound, pass_end,
      input  ready
   );
   modport sink (
      input  valid, var_index, current_value, upper_bound, lower_bound, pass_end,
      output ready
   );
endinterface

interface masu_rsp_if;
   import masu_pkg::*;

   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   out_index;
   logic [WIDTH_W-1:0] new_width;
   logic               out_last;

   modport source (
      output valid, out_index, new_width, out_last,
      input  ready
   );
   modport sink (
      input  valid, out_index, new_width, out_last,
      output ready
   );
endinterface

@@ rtl/masu_hist_mem.sv @@
module masu_hist_mem
   import masu_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic           clock,
   input  logic           rd_en,
   input  logic [AW-1:0]  rd_addr,
   output hist_entry_type rd_data_ff,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  hist_entry_type wr_data
);

   hist_entry_type mem [DEPTH];

   // read-first on a same-address collision; the pipeline forwards around it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/masu_update.sv @@
module masu_update
   import masu_pkg::*;
#(
   parameter int AW = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  item_type       in_item,
   input  logic [AW-1:0]  in_slot,
   input  hist_entry_type mem_q,
   input  cfg_type        cfg,
   output logic           wr_en,
   output logic [AW-1:0]  wr_slot,
   output hist_entry_type wr_data,
   output logic           rsp_push,
   output result_type     rsp_data
);

   // stage 1: history lookup, sign test, multiplies
   logic           s1_v_ff;
   item_type       s1_item_ff;
   logic [AW-1:0]  s1_slot_ff;

   // stage 2: rounding, clamp, saturate, write back
   logic                    s2_v_ff;
   logic [AW-1:0]           s2_slot_ff;
   logic [IDX_W-1:0]        s2_idx_ff;
   logic signed [VAL_W-1:0] s2_x_ff;
   logic signed [VAL_W-1:0] s2_prev_ff;
   logic                    s2_last_ff;
   logic                    s2_warm_ff;
   logic [54:0]             s2_pw_ff;
   logic signed [56:0]      s2_plo_ff;
   logic signed [56:0]      s2_phi_ff;
   logic signed [32:0]      s2_half_ff;

   // last write, covers the read issued on the same edge
   logic           wb_v_ff;
   logic [AW-1:0]  wb_slot_ff;
   hist_entry_type wb_data_ff;

   hist_entry_type     hist;
   hist_entry_type     wr_entry;
   logic signed [32:0] range;
   logic signed [33:0] range_adj;
   logic signed [32:0] half;
   logic signed [32:0] d_new;
   logic signed [32:0] d_old;
   logic [CFG_W-1:0]   factor;
   logic [54:0]        pw_in;
   logic signed [56:0] plo_in;
   logic signed [56:0] phi_in;
   logic signed [56:0] lo_adj;
   logic signed [56:0] hi_adj;
   logic signed [40:0] lo;
   logic signed [40:0] hi;
   logic signed [40:0] wm;
   logic signed [40:0] wc;
   logic [WIDTH_W-1:0] w_sat;

   // ---------------- stage 1 ----------------
   always_comb begin
      hist = mem_q;
      if (wb_v_ff && (wb_slot_ff == s1_slot_ff)) begin
         hist = wb_data_ff;
      end
      if (s2_v_ff && (s2_slot_ff == s1_slot_ff)) begin
         hist = wr_entry;
      end
   end

   always_comb begin
      range     = 33'(s1_item_ff.upper_bound) - 33'(s1_item_ff.lower_bound);
      range_adj = 34'(range) + (range[32] ? 34'sd1 : 34'sd0);
      half      = 33'(range_adj >>> 1);
      d_new     = 33'(s1_item_ff.current_value) - 33'(hist.prev_value);
      d_old     = 33'(hist.prev_value) - 33'(hist.older_value);
      factor    = Q_ONE;
      if ((d_new != 33'sd0) && (d_old != 33'sd0)) begin
         factor = (d_new[32] == d_old[32]) ? cfg.expansion_factor : cfg.contraction_factor;
      end
      pw_in  = 55'(hist.width) * 55'(factor);
      plo_in = 57'(range) * 57'($signed({1'b0, cfg.min_width_scale}));
      phi_in = 57'(range) * 57'($signed({1'b0, cfg.max_width_scale}));
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      // truncate toward zero
      lo_adj = s2_plo_ff + (s2_plo_ff[56] ? 57'sd65535 : 57'sd0);
      hi_adj = s2_phi_ff + (s2_phi_ff[56] ? 57'sd65535 : 57'sd0);
      lo     = 41'(lo_adj >>> 16);
      hi     = 41'(hi_adj >>> 16);
      wm     = $signed(41'(s2_pw_ff >> 16));
      if (s2_warm_ff) begin
         wc = wm;
         if (lo > wc) begin
            wc = lo;
         end
         if (hi < wc) begin
            wc = hi;
         end
      end else begin
         wc = 41'(s2_half_ff);
      end
      if (wc[40]) begin
         w_sat = '0;
      end else if (|wc[39:31]) begin
         w_sat = '1;
      end else begin
         w_sat = wc[30:0];
      end
      wr_entry.prev_value  = s2_x_ff;
      wr_entry.older_value = s2_prev_ff;
      wr_entry.width       = w_sat;
   end

   assign wr_en    = adv && s2_v_ff;
   assign wr_slot  = s2_slot_ff;
   assign wr_data  = wr_entry;
   assign rsp_push = adv && s2_v_ff;
   assign rsp_data = '{out_index: s2_idx_ff, new_width: w_sat, out_last: s2_last_ff};

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         wb_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_item.valid;
         s2_v_ff <= s1_v_ff;
         wb_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= in_item;
         s1_slot_ff <= in_slot;
         s2_slot_ff <= s1_slot_ff;
         s2_idx_ff  <= s1_item_ff.var_index;
         s2_x_ff    <= s1_item_ff.current_value;
         s2_prev_ff <= hist.prev_value;
         s2_last_ff <= s1_item_ff.pass_end;
         s2_warm_ff <= s1_item_ff.warm;
         s2_pw_ff   <= pw_in;
         s2_plo_ff  <= plo_in;
         s2_phi_ff  <= phi_in;
         s2_half_ff <= half;
         wb_slot_ff <= s2_slot_ff;
         wb_data_ff <= wr_entry;
      end
   end

endmodule

@@ rtl/masu_out_fifo.sv @@
module masu_out_fifo
   import masu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   masu_rsp_if.source rsp_ch
);

   result_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;
   result_type head;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign full = (count_ff == 2'd2);
   assign head = slot_ff[rd_ptr_ff];

   assign rsp_ch.valid     = (count_ff != 2'd0);
   assign rsp_ch.out_index = head.out_index;
   assign rsp_ch.new_width = head.new_width;
   assign rsp_ch.out_last  = head.out_last;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/moving_asymptote_sigma_update_unit.sv @@
// Pipeline: stage 1 registers, stage 2 registers, then the output queue.
// Throughput: one request per cycle; the history memory is read once and
// written once per request, and req ready drops only while both output
// slots hold results not yet taken.
// Reset: synchronous, active high; clears pass count, pipeline valids and output
// queue, loads register defaults. History memory is not cleared.
module moving_asymptote_sigma_update_unit
   import masu_pkg::*;
#(
   parameter int NUM_VARS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   masu_req_if.sink    req_ch,
   masu_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
   localparam logic [1:0] PASS_WARM = 2'd2;

   // config registers
   cfg_type cfg_ff;

   // completed passes, saturating at two
   logic [1:0] pc_ff;
   logic [1:0] pc_in;

   logic           adv;
   logic           req_accept;
   logic           fifo_full;
   logic [AW-1:0]  slot;
   item_type       in_item;
   hist_entry_type mem_q;
   logic           wr_en;
   logic [AW-1:0]  wr_slot;
   hist_entry_type wr_data;
   logic           rsp_push;
   result_type     rsp_data;

   // Whole pipeline moves together whenever the output queue has room.
   assign adv          = !fifo_full;
   assign req_ch.ready = adv;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Slot = var_index mod NUM_VARS. Below 1024 entries the quotient comes
   // from a reciprocal multiply (exact for all 10-bit indexes), then one
   // multiply-subtract leaves the remainder.
   generate
      if (NUM_VARS >= (1 << IDX_W)) begin : g_slot_direct
         assign slot = AW'(req_ch.var_index);
      end else begin : g_slot_mod
         localparam logic [20:0] RECIP = 21'(((1 << 20) + NUM_VARS - 1) / NUM_VARS);
         logic [30:0]      prod;
         logic [IDX_W-1:0] quot;
         logic [19:0]      back;
         logic [IDX_W-1:0] rem;
         always_comb begin
            prod = 31'(req_ch.var_index) * 31'(RECIP);
            quot = prod[29:20];
            back = 20'(quot) * 20'(NUM_VARS);
            rem  = req_ch.var_index - back[IDX_W-1:0];
         end
         assign slot = AW'(rem);
      end
   endgenerate

   // Warm flag: the pass count seen by this request, before its own pass_end, is two.
   always_comb begin
      in_item.valid         = req_accept;
      in_item.var_index     = req_ch.var_index;
      in_item.current_value = req_ch.current_value;
      in_item.upper_bound   = req_ch.upper_bound;
      in_item.lower_bound   = req_ch.lower_bound;
      in_item.pass_end      = req_ch.pass_end;
      in_item.warm          = (pc_ff == PASS_WARM);
   end

   always_comb begin
      pc_in = pc_ff;
      if (req_accept && req_ch.pass_end && (pc_ff != PASS_WARM)) begin
         pc_in = pc_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff                     <= 2'd0;
         cfg_ff.expansion_factor   <= EXPANSION_RESET;
         cfg_ff.contraction_factor <= CONTRACTION_RESET;
         cfg_ff.min_width_scale    <= MIN_SCALE_RESET;
         cfg_ff.max_width_scale    <= MAX_SCALE_RESET;
      end else begin
         pc_ff <= pc_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_EXPANSION:   cfg_ff.expansion_factor   <= csr_wdata;
               CSR_CONTRACTION: cfg_ff.contraction_factor <= csr_wdata;
               CSR_MIN_SCALE:   cfg_ff.min_width_scale    <= csr_wdata;
               CSR_MAX_SCALE:   cfg_ff.max_width_scale    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // History: previous value, older value and width per variable.
   masu_hist_mem #(
      .DEPTH (NUM_VARS),
      .AW    (AW)
   ) u_hist_mem (
      .clock      (clock),
      .rd_en      (adv),
      .rd_addr    (slot),
      .rd_data_ff (mem_q),
      .wr_en      (wr_en),
      .wr_addr    (wr_slot),
      .wr_data    (wr_data)
   );

   // Two-stage read-modify-write with forwarding from the write stage and
   // from the last write.
   masu_update #(
      .AW (AW)
   ) u_update (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_item  (in_item),
      .in_slot  (slot),
      .mem_q    (mem_q),
      .cfg      (cfg_ff),
      .wr_en    (wr_en),
      .wr_slot  (wr_slot),
      .wr_data  (wr_data),
      .rsp_push (rsp_push),
      .rsp_data (rsp_data)
   );

   // Two-entry output queue decouples rsp ready from req ready.
   masu_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (fifo_full),
      .rsp_ch    (rsp_ch)
   );

   // ---------------- assertions ----------------
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff != 2'd3)
      else $error("pass count beyond two");

   a_pc_moves_on_last: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (pc_ff != $past(pc_ff))) |->
         ($past(req_accept) && $past(req_ch.pass_end)))
      else $error("pass count changed without a last request");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !fifo_full)
      else $error("result pushed into a full output queue");

   a_stall_means_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("request stalled with no result pending");

endmodule
